FILE: design/rbst_pkg.sv
package rbst_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS + 1;
  localparam int AXES       = 3;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECIP_DIR_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECIP_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECIP_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_SIGNS   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED      = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    coord_t [AXES-1:0]   origin;
    coord_t [AXES-1:0]   recip;
    logic   [AXES-1:0]   signs;
  } ray_cfg_t;

  typedef struct packed {
    coord_t [AXES-1:0] bmin;
    coord_t [AXES-1:0] bmax;
    coord_t            limit;
  } box_t;

  typedef struct packed {
    diff_t [AXES-1:0] d_near;
    diff_t [AXES-1:0] d_far;
    coord_t           limit;
  } diff_stage_t;

  typedef struct packed {
    prod_t [AXES-1:0] t_in;
    prod_t [AXES-1:0] t_out;
    prod_t            lim;
  } prod_stage_t;

  typedef struct packed {
    logic valid;
    logic en;
  } stage_ctl_t;

endpackage

FILE: design/rbst_if.sv
interface rbst_box_if;
  logic                   valid;
  logic                   ready;
  rbst_pkg::coord_t       box_min_x;
  rbst_pkg::coord_t       box_min_y;
  rbst_pkg::coord_t       box_min_z;
  rbst_pkg::coord_t       box_max_x;
  rbst_pkg::coord_t       box_max_y;
  rbst_pkg::coord_t       box_max_z;
  rbst_pkg::coord_t       dist_limit;

  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, dist_limit, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, dist_limit, output ready);
endinterface

interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

interface rbst_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rbst_pkg::CFG_IDX_BITS-1:0]   index;
  logic [rbst_pkg::COORD_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/rbst_diff.sv
module rbst_diff (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rbst_pkg::stage_ctl_t   ctl_in,
  input  rbst_pkg::box_t         box,
  input  rbst_pkg::ray_cfg_t     ray,
  output logic                   valid_out,
  output rbst_pkg::diff_stage_t  dat_out
);
  import rbst_pkg::*;

  logic        valid_r;
  diff_stage_t dat_r;
  diff_stage_t dat_nxt;

  always_comb begin
    dat_nxt.limit = box.limit;
    for (int a = 0; a < AXES; a++) begin
      dat_nxt.d_near[a] = ray.signs[a]
          ? diff_t'(box.bmax[a]) - diff_t'(ray.origin[a])
          : diff_t'(box.bmin[a]) - diff_t'(ray.origin[a]);
      dat_nxt.d_far[a] = ray.signs[a]
          ? diff_t'(box.bmin[a]) - diff_t'(ray.origin[a])
          : diff_t'(box.bmax[a]) - diff_t'(ray.origin[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_in.en) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      dat_r <= dat_nxt;
    end
  end

  assign valid_out = valid_r;
  assign dat_out   = dat_r;
endmodule

FILE: design/rbst_mul.sv
module rbst_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rbst_pkg::stage_ctl_t   ctl_in,
  input  rbst_pkg::diff_stage_t  dat_in,
  input  rbst_pkg::ray_cfg_t     ray,
  output logic                   valid_out,
  output rbst_pkg::prod_stage_t  dat_out
);
  import rbst_pkg::*;

  logic        valid_r;
  prod_stage_t dat_r;
  prod_stage_t dat_nxt;

  always_comb begin
    dat_nxt.lim = prod_t'(dat_in.limit) <<< FRAC_BITS;
    for (int a = 0; a < AXES; a++) begin
      dat_nxt.t_in[a]  = prod_t'(dat_in.d_near[a]) * prod_t'(ray.recip[a]);
      dat_nxt.t_out[a] = prod_t'(dat_in.d_far[a]) * prod_t'(ray.recip[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_in.en) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      dat_r <= dat_nxt;
    end
  end

  assign valid_out = valid_r;
  assign dat_out   = dat_r;
endmodule

FILE: design/rbst_cmp.sv
module rbst_cmp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rbst_pkg::stage_ctl_t   ctl_in,
  input  rbst_pkg::prod_stage_t  dat_in,
  output logic                   valid_out,
  output logic                   hit_out
);
  import rbst_pkg::*;

  logic  pair_valid_r;
  prod_t lo_a_r, lo_b_r, hi_a_r, hi_b_r;
  prod_t lo_a_nxt, lo_b_nxt, hi_a_nxt, hi_b_nxt;
  logic  span_valid_r;
  prod_t lo_r, hi_r;
  prod_t lo_nxt, hi_nxt;
  logic  out_valid_r;
  logic  hit_r;

  always_comb begin
    lo_a_nxt = (dat_in.t_in[0] > prod_t'(0)) ? dat_in.t_in[0] : prod_t'(0);
    lo_b_nxt = (dat_in.t_in[1] > dat_in.t_in[2]) ? dat_in.t_in[1] : dat_in.t_in[2];
    hi_a_nxt = (dat_in.lim > dat_in.t_out[0]) ? dat_in.t_out[0] : dat_in.lim;
    hi_b_nxt = (dat_in.t_out[1] > dat_in.t_out[2]) ? dat_in.t_out[2] : dat_in.t_out[1];
    lo_nxt   = (lo_a_r > lo_b_r) ? lo_a_r : lo_b_r;
    hi_nxt   = (hi_a_r > hi_b_r) ? hi_b_r : hi_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= 1'b0;
      span_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (ctl_in.en) begin
      pair_valid_r <= ctl_in.valid;
      span_valid_r <= pair_valid_r;
      out_valid_r  <= span_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      lo_a_r <= lo_a_nxt;
      lo_b_r <= lo_b_nxt;
      hi_a_r <= hi_a_nxt;
      hi_b_r <= hi_b_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      hit_r  <= !(lo_r > hi_r);
    end
  end

  assign valid_out = out_valid_r;
  assign hit_out   = hit_r;
endmodule

FILE: design/ray_box_slab_test_core.sv
// Ray versus axis-aligned box slab test on signed Q16.16 values. Load the ray (origin,
// reciprocal direction, direction sign bits) through the configuration channel while no
// item is in flight; each write is taken in the cycle it is offered. After that one box
// item is taken every cycle while the result side is not stalled, and its hit bit is
// formed in a pipeline: one stage forms the plane-minus-origin differences, one stage holds
// the six 33x32 multipliers, two stages reduce the entry and exit distances, and the last
// stage compares them into the output register. A stalled result holds the whole pipeline,
// so ready on the box side follows the result side whenever the output register is full.
module ray_box_slab_test_core (
  input  logic        clk,
  input  logic        rst_n,
  rbst_box_if.sink    in_box,
  rbst_hit_if.source  out_hit,
  rbst_cfg_if.sink    cfg_wr
);
  import rbst_pkg::*;

  ray_cfg_t    ray_r;
  box_t        box;
  stage_ctl_t  ctl_diff, ctl_mul, ctl_cmp;
  logic        en;
  logic        diff_valid, mul_valid, cmp_valid;
  diff_stage_t diff_dat;
  prod_stage_t mul_dat;
  logic        hit;

  assign en           = !cmp_valid || out_hit.ready;
  assign in_box.ready = en;
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    box.bmin[0] = in_box.box_min_x;
    box.bmin[1] = in_box.box_min_y;
    box.bmin[2] = in_box.box_min_z;
    box.bmax[0] = in_box.box_max_x;
    box.bmax[1] = in_box.box_max_y;
    box.bmax[2] = in_box.box_max_z;
    box.limit   = in_box.dist_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_ORIGIN_X:    ray_r.origin[0] <= cfg_wr.data;
        CFG_ORIGIN_Y:    ray_r.origin[1] <= cfg_wr.data;
        CFG_ORIGIN_Z:    ray_r.origin[2] <= cfg_wr.data;
        CFG_RECIP_DIR_X: ray_r.recip[0]  <= cfg_wr.data;
        CFG_RECIP_DIR_Y: ray_r.recip[1]  <= cfg_wr.data;
        CFG_RECIP_DIR_Z: ray_r.recip[2]  <= cfg_wr.data;
        CFG_DIR_SIGNS:   ray_r.signs     <= cfg_wr.data[AXES-1:0];
        default: ;
      endcase
    end
  end

  assign ctl_diff = '{valid: in_box.valid, en: en};
  assign ctl_mul  = '{valid: diff_valid, en: en};
  assign ctl_cmp  = '{valid: mul_valid, en: en};

  rbst_diff u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_diff),
    .box       (box),
    .ray       (ray_r),
    .valid_out (diff_valid),
    .dat_out   (diff_dat)
  );

  rbst_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_mul),
    .dat_in    (diff_dat),
    .ray       (ray_r),
    .valid_out (mul_valid),
    .dat_out   (mul_dat)
  );

  rbst_cmp u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_cmp),
    .dat_in    (mul_dat),
    .valid_out (cmp_valid),
    .hit_out   (hit)
  );

  assign out_hit.valid = cmp_valid;
  assign out_hit.hit   = hit;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_hit.valid)
    else $error("result valid right after reset");

  a_neg_limit_miss: assert property (@(posedge clk) disable iff (!rst_n)
      (mul_valid && mul_dat.lim < prod_t'(0) && en) ##1 en ##1 en
      |=> (out_hit.valid && !out_hit.hit))
    else $error("negative distance limit produced a hit");

  a_unused_index: assert property (@(posedge clk) disable iff (!rst_n)
      (cfg_wr.valid && cfg_wr.index == CFG_UNUSED) |=> $stable(ray_r))
    else $error("write to unused register index changed the ray");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (!en && mul_valid) |=> (mul_valid && $stable(mul_dat)))
    else $error("product stage changed during a stall");
endmodule
